### rtl/ps_pkg.sv
// shared types, codes and letter/square helper functions of the playfair stream cipher
package ps_pkg;

  localparam int unsigned NumCells   = 25;
  localparam int unsigned NumLetters = 26;
  localparam logic [4:0]  LetterI    = 5'd8;
  localparam logic [4:0]  LetterJ    = 5'd9;
  localparam logic [4:0]  LetterX    = 5'd23;
  localparam logic [4:0]  LastLetter = 5'd25;
  localparam logic [4:0]  FullCount  = 5'd25;
  localparam logic [6:0]  AsciiA     = 7'd65;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_TEXT  = 2'd2,
    OP_END   = 2'd3
  } ps_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_TEXT,
    ST_RD_A,
    ST_RD_B,
    ST_MAP,
    ST_SQ_A,
    ST_SQ_B,
    ST_OUT0,
    ST_OUT1
  } ps_state_e;

  typedef struct packed {
    logic       we;
    logic [4:0] waddr;
    logic [4:0] wdata;
    logic [4:0] raddr;
  } ps_ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] letter;
    logic       last;
  } ps_out_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] idx;
  } ps_letter_t;

  // ascii byte to letter index, j folded to i
  function automatic ps_letter_t letter_of(input logic [7:0] b);
    ps_letter_t r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      d = b - 8'h61;
      r.valid = 1'b1;
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      d = b - 8'h41;
      r.valid = 1'b1;
    end
    r.idx = d[4:0];
    if (r.idx == LetterJ) begin
      r.idx = LetterI;
    end
    return r;
  endfunction

  // row of a cell 0..24: p*13 >> 6 equals p/5 over that range
  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [8:0] m;
    m = {4'b0000, p} * 9'd13;
    return m[8:6];
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [2:0] r;
    logic [4:0] c;
    r = row_of(p);
    c = p - {r, 2'b00} - {2'b00, r};
    return c[2:0];
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // one step round the row or column: forward to encrypt, back to decrypt
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

### rtl/ps_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module ps_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/ps_ctrl.sv
// sequencer: key entry, square completion, pairing and the pair lookup through both rams
module ps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mode_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_op_i,
  input  logic [7:0]          in_char_i,
  output ps_pkg::ps_ram_req_t sq_req_o,
  input  logic [4:0]          sq_rdata_i,
  output ps_pkg::ps_ram_req_t pos_req_o,
  input  logic [4:0]          pos_rdata_i,
  output ps_pkg::ps_out_t     out_o,
  input  logic                out_ready_i
);

  ps_pkg::ps_state_e state_q, state_d;

  logic [25:0] used_q, used_d;
  logic [4:0]  fill_q, fill_d;
  logic        complete_q, complete_d;
  logic [4:0]  held_q, held_d;
  logic        held_v_q, held_v_d;
  logic [4:0]  scan_q, scan_d;
  logic [7:0]  chr_q, chr_d;
  logic [4:0]  pa_q, pa_d;
  logic [4:0]  pb_q, pb_d;
  logic [4:0]  p1_q, p1_d;
  logic [4:0]  o2_q, o2_d;
  logic [4:0]  l0_q, l0_d;
  logic [4:0]  l1_q, l1_d;

  logic               accept;
  ps_pkg::ps_op_e     op;
  ps_pkg::ps_letter_t in_let, text_let;
  logic               place_en;
  logic [4:0]         place_idx;
  logic               pair_now;
  logic [2:0]         r1, c1, r2, c2;
  logic [4:0]         o1, o2;

  assign accept   = in_valid_i && in_ready_o;
  assign op       = ps_pkg::ps_op_e'(in_op_i);
  assign in_let   = ps_pkg::letter_of(in_char_i);
  assign text_let = ps_pkg::letter_of(chr_q);

  // a text letter that completes a pair
  assign pair_now = (state_q == ps_pkg::ST_TEXT) && text_let.valid && held_v_q;

  always_comb begin
    place_en  = 1'b0;
    place_idx = in_let.idx;
    if (state_q == ps_pkg::ST_IDLE) begin
      place_en = accept && (op == ps_pkg::OP_KEY) && !complete_q && in_let.valid &&
                 !used_q[in_let.idx] && (fill_q < ps_pkg::FullCount);
    end else if (state_q == ps_pkg::ST_FILL) begin
      place_idx = scan_q;
      place_en  = (scan_q != ps_pkg::LetterJ) && !used_q[scan_q] &&
                  (fill_q < ps_pkg::FullCount);
    end
  end

  // pair mapping from the two cell positions
  always_comb begin
    r1 = ps_pkg::row_of(p1_q);
    c1 = ps_pkg::col_of(p1_q);
    r2 = ps_pkg::row_of(pos_rdata_i);
    c2 = ps_pkg::col_of(pos_rdata_i);
    if (r1 == r2) begin
      o1 = ps_pkg::cell_of(r1, ps_pkg::wrap_step(c1, mode_i));
      o2 = ps_pkg::cell_of(r2, ps_pkg::wrap_step(c2, mode_i));
    end else if (c1 == c2) begin
      o1 = ps_pkg::cell_of(ps_pkg::wrap_step(r1, mode_i), c1);
      o2 = ps_pkg::cell_of(ps_pkg::wrap_step(r2, mode_i), c2);
    end else begin
      o1 = ps_pkg::cell_of(r1, c2);
      o2 = ps_pkg::cell_of(r2, c1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ps_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == ps_pkg::OP_TEXT) begin
            state_d = complete_q ? ps_pkg::ST_TEXT : ps_pkg::ST_FILL;
          end else if (op == ps_pkg::OP_END && held_v_q) begin
            state_d = ps_pkg::ST_RD_A;
          end
        end
      end
      ps_pkg::ST_FILL: begin
        if (scan_q == ps_pkg::LastLetter) begin
          state_d = ps_pkg::ST_TEXT;
        end
      end
      ps_pkg::ST_TEXT: begin
        state_d = pair_now ? ps_pkg::ST_RD_A : ps_pkg::ST_IDLE;
      end
      ps_pkg::ST_RD_A: state_d = ps_pkg::ST_RD_B;
      ps_pkg::ST_RD_B: state_d = ps_pkg::ST_MAP;
      ps_pkg::ST_MAP:  state_d = ps_pkg::ST_SQ_A;
      ps_pkg::ST_SQ_A: state_d = ps_pkg::ST_SQ_B;
      ps_pkg::ST_SQ_B: state_d = ps_pkg::ST_OUT0;
      ps_pkg::ST_OUT0: begin
        if (out_ready_i) begin
          state_d = ps_pkg::ST_OUT1;
        end
      end
      ps_pkg::ST_OUT1: begin
        if (out_ready_i) begin
          state_d = ps_pkg::ST_IDLE;
        end
      end
      default: state_d = ps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    sq_req_o.we     = place_en;
    sq_req_o.waddr  = fill_q;
    sq_req_o.wdata  = place_idx;
    sq_req_o.raddr  = '0;
    pos_req_o.we    = place_en;
    pos_req_o.waddr = place_idx;
    pos_req_o.wdata = fill_q;
    pos_req_o.raddr = '0;
    out_o.valid     = 1'b0;
    out_o.letter    = ps_pkg::AsciiA + {2'b00, l0_q};
    out_o.last      = 1'b0;
    case (state_q)
      ps_pkg::ST_IDLE: in_ready_o = 1'b1;
      ps_pkg::ST_RD_A: pos_req_o.raddr = pa_q;
      ps_pkg::ST_RD_B: pos_req_o.raddr = pb_q;
      ps_pkg::ST_MAP:  sq_req_o.raddr = o1;
      ps_pkg::ST_SQ_A: sq_req_o.raddr = o2_q;
      ps_pkg::ST_OUT0: out_o.valid = 1'b1;
      ps_pkg::ST_OUT1: begin
        out_o.valid  = 1'b1;
        out_o.letter = ps_pkg::AsciiA + {2'b00, l1_q};
        out_o.last   = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath and key state
  always_comb begin
    used_d     = used_q;
    fill_d     = fill_q;
    complete_d = complete_q;
    held_d     = held_q;
    held_v_d   = held_v_q;
    scan_d     = scan_q;
    chr_d      = chr_q;
    pa_d       = pa_q;
    pb_d       = pb_q;
    p1_d       = p1_q;
    o2_d       = o2_q;
    l0_d       = l0_q;
    l1_d       = l1_q;
    if (place_en) begin
      used_d[place_idx] = 1'b1;
      fill_d            = fill_q + 5'd1;
    end
    case (state_q)
      ps_pkg::ST_IDLE: begin
        if (accept) begin
          chr_d  = in_char_i;
          scan_d = '0;
          if (op == ps_pkg::OP_CLEAR) begin
            used_d     = '0;
            fill_d     = '0;
            complete_d = 1'b0;
            held_v_d   = 1'b0;
          end else if (op == ps_pkg::OP_END && held_v_q) begin
            pa_d     = held_q;
            pb_d     = ps_pkg::LetterX;
            held_v_d = 1'b0;
          end
        end
      end
      ps_pkg::ST_FILL: begin
        scan_d = scan_q + 5'd1;
        if (scan_q == ps_pkg::LastLetter) begin
          complete_d = 1'b1;
        end
      end
      ps_pkg::ST_TEXT: begin
        if (text_let.valid) begin
          if (!held_v_q) begin
            held_d   = text_let.idx;
            held_v_d = 1'b1;
          end else if (!mode_i && held_q == text_let.idx) begin
            // doubled letter: pad with x and keep the second one held
            pa_d = held_q;
            pb_d = ps_pkg::LetterX;
          end else begin
            pa_d     = held_q;
            pb_d     = text_let.idx;
            held_v_d = 1'b0;
          end
        end
      end
      ps_pkg::ST_RD_B: p1_d = pos_rdata_i;
      ps_pkg::ST_MAP:  o2_d = o2;
      ps_pkg::ST_SQ_A: l0_d = sq_rdata_i;
      ps_pkg::ST_SQ_B: l1_d = sq_rdata_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ps_pkg::ST_IDLE;
      used_q     <= '0;
      fill_q     <= '0;
      complete_q <= 1'b0;
      held_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      fill_q     <= fill_d;
      complete_q <= complete_d;
      held_v_q   <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    scan_q <= scan_d;
    chr_q  <= chr_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    p1_q   <= p1_d;
    o2_q   <= o2_d;
    l0_q   <= l0_d;
    l1_q   <= l1_d;
  end

endmodule

### rtl/playfair_stream_cipher.sv
// playfair stream cipher top level: mode register, square rams, sequencer and output register
//
// Input beats carry an operation on s_axis_tuser_i (clear key, key char, text char, end of
// text) and an ascii byte on s_axis_tdata_i. Output beats carry one ciphertext or plaintext
// letter on m_axis_tdata_o, with m_axis_tlast_o high on the second letter of each pair.
// cfg_we_i writes cfg_wdata_i into the mode register (0 encrypt, 1 decrypt); the user is to
// write it only while idle, which the block itself does not enforce. Clear and key beats
// are handled in the idle state. The first text beat after a clear first walks the alphabet
// once, one letter a cycle, to finish the square. A text beat that only holds a letter
// passes through the text state back to idle; one that completes a pair, or an
// end-of-text beat with a letter held, reads the position ram twice and the square ram
// twice, one port each, then offers the first letter and after it the second; the next beat
// is taken once both letters sit in or have passed the output register.
// Reset empties the key, drops any held letter and sets encrypt mode; the ram contents
// are only read once written. A stalled receiver holds the output register and the
// sequencer waits; no beat is lost.
module playfair_stream_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  logic [1:0] s_axis_tuser_i,   // [1:0] operation
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] letter, [7] zero fill
  output logic       m_axis_tlast_o
);

  logic                mode_q;
  ps_pkg::ps_ram_req_t sq_req, pos_req;
  logic [4:0]          sq_rdata, pos_rdata;
  ps_pkg::ps_out_t     ctrl_out;
  logic                out_room;
  logic                out_valid_q;
  logic [6:0]          out_letter_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  ps_ram #(
    .Width (5),
    .Depth (ps_pkg::NumCells)
  ) u_square (
    .clk_i   (clk_i),
    .we_i    (sq_req.we),
    .waddr_i (sq_req.waddr),
    .wdata_i (sq_req.wdata),
    .raddr_i (sq_req.raddr),
    .rdata_o (sq_rdata)
  );

  ps_ram #(
    .Width (5),
    .Depth (ps_pkg::NumLetters)
  ) u_position (
    .clk_i   (clk_i),
    .we_i    (pos_req.we),
    .waddr_i (pos_req.waddr),
    .wdata_i (pos_req.wdata),
    .raddr_i (pos_req.raddr),
    .rdata_o (pos_rdata)
  );

  ps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_char_i   (s_axis_tdata_i),
    .sq_req_o    (sq_req),
    .sq_rdata_i  (sq_rdata),
    .pos_req_o   (pos_req),
    .pos_rdata_i (pos_rdata),
    .out_o       (ctrl_out),
    .out_ready_i (out_room)
  );

  // output register takes a new beat when empty or being drained
  assign out_room = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_room) begin
      out_valid_q <= ctrl_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_room && ctrl_out.valid) begin
      out_letter_q <= ctrl_out.letter;
      out_last_q   <= ctrl_out.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_letter_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // the sequencer never offers a letter while it is taking input beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !ctrl_out.valid)
    else $error("letter offered while input ready");

  // every letter leaving the block is an uppercase letter other than j
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o >= 8'd65 && m_axis_tdata_o <= 8'd90 &&
                         m_axis_tdata_o != 8'd74))
    else $error("output letter out of range");

  // a first letter of a pair is always followed by its second one from the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_out.valid && !ctrl_out.last && out_room) |=> (ctrl_out.valid && ctrl_out.last))
    else $error("pair broken in sequencer");
`endif

endmodule

### dv/playfair_stream_cipher_tb.sv
// testbench of the playfair stream cipher: directed table, then random messages against a predictor
module testbench;

  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned PhaseBeats = 250;
  localparam int unsigned MaxPrinted = 50;

  typedef struct {
    logic [6:0] letter;
    logic       last;
  } letter_beat_t;

  typedef struct {
    ps_pkg::ps_op_e op;
    logic [7:0]     chr;
    bit             typed;
    int             n;
    logic [7:0]     l0;
    logic [7:0]     l1;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'd0;
  logic [1:0] s_tuser   = 2'd0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sink_hold      = 0;
  int beats_in       = 0;
  int n_errors       = 0;
  int idle_cycles    = 0;

  letter_beat_t expected_letters[$];

  // predictor copy of the block state
  logic        pf_mode = 1'b0;
  logic [4:0]  sq_cell [ps_pkg::NumCells];
  logic [4:0]  sq_pos [ps_pkg::NumLetters];
  logic [25:0] sq_used  = '0;
  int          sq_fill  = 0;
  bit          sq_done  = 1'b0;
  logic [4:0]  held_idx = '0;
  bit          held_ok  = 1'b0;

  // empty key, so the square is the plain alphabet: ABCDE FGHIK LMNOP QRSTU VWXYZ
  dir_row_t dir_tab [25] = '{
    '{ps_pkg::OP_TEXT,  "A",   1, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "B",   1, 2, "B",  "C"},
    '{ps_pkg::OP_TEXT,  "a",   1, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "A",   1, 2, "C",  "V"},   // doubled letter split with x
    '{ps_pkg::OP_TEXT,  "F",   1, 2, "F",  "L"},   // column rule
    '{ps_pkg::OP_TEXT,  "Z",   1, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "z",   1, 2, "V",  "Y"},   // row rule wraps round
    '{ps_pkg::OP_END,   8'h00, 1, 2, "V",  "Y"},   // lone letter padded
    '{ps_pkg::OP_END,   8'hff, 1, 0, 8'd0, 8'd0},  // nothing held
    '{ps_pkg::OP_TEXT,  8'h00, 1, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  8'hff, 1, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "J",   1, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "j",   1, 2, "H",  "Y"},   // j folds to i
    '{ps_pkg::OP_CLEAR, 8'hff, 1, 0, 8'd0, 8'd0},  // drops the held i
    '{ps_pkg::OP_KEY,   "P",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_KEY,   "l",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_KEY,   8'h40, 0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_KEY,   "p",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_KEY,   "J",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_KEY,   "z",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "H",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_KEY,   "Q",   0, 0, 8'd0, 8'd0},  // square already complete
    '{ps_pkg::OP_TEXT,  "i",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_TEXT,  "E",   0, 0, 8'd0, 8'd0},
    '{ps_pkg::OP_END,   8'h7b, 0, 0, 8'd0, 8'd0}
  };

  bit ph_mode [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  int ph_src  [NumPhases] = '{0, 76, 0, 22, 0, 76, 0};
  int ph_sink [NumPhases] = '{0, 0, 76, 22, 0, 76, 22};

  playfair_stream_cipher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit to_letter(input logic [7:0] b, output logic [4:0] idx);
    logic [7:0] d;
    d = 8'd0;
    idx = '0;
    if (b >= "a" && b <= "z") begin
      d = b - "a";
    end else if (b >= "A" && b <= "Z") begin
      d = b - "A";
    end else begin
      return 1'b0;
    end
    idx = d[4:0];
    if (idx == ps_pkg::LetterJ) begin
      idx = ps_pkg::LetterI;
    end
    return 1'b1;
  endfunction

  function automatic void sq_place(input logic [4:0] idx);
    if (sq_fill < ps_pkg::NumCells) begin
      sq_cell[sq_fill] = idx;
      sq_pos[idx]      = 5'(sq_fill);
      sq_used[idx]     = 1'b1;
      sq_fill++;
    end
  endfunction

  function automatic void sq_complete();
    if (!sq_done) begin
      for (int i = 0; i < ps_pkg::NumLetters; i++) begin
        if (i != ps_pkg::LetterJ && !sq_used[i]) begin
          sq_place(5'(i));
        end
      end
      sq_done = 1'b1;
    end
  endfunction

  function automatic void push_pair(input logic [4:0] a, input logic [4:0] b);
    int r1, c1, r2, c2, o1, o2, step;
    r1 = sq_pos[a] / 5;
    c1 = sq_pos[a] % 5;
    r2 = sq_pos[b] / 5;
    c2 = sq_pos[b] % 5;
    step = pf_mode ? 4 : 1;
    if (r1 == r2) begin
      o1 = r1 * 5 + (c1 + step) % 5;
      o2 = r2 * 5 + (c2 + step) % 5;
    end else if (c1 == c2) begin
      o1 = ((r1 + step) % 5) * 5 + c1;
      o2 = ((r2 + step) % 5) * 5 + c2;
    end else begin
      o1 = r1 * 5 + c2;
      o2 = r2 * 5 + c1;
    end
    expected_letters.push_back('{ps_pkg::AsciiA + 7'(sq_cell[o1]), 1'b0});
    expected_letters.push_back('{ps_pkg::AsciiA + 7'(sq_cell[o2]), 1'b1});
  endfunction

  // advance the state for one beat; letters are dropped when the table supplies them
  function automatic void predict_letters(input ps_pkg::ps_op_e op, input logic [7:0] chr,
                                          input bit keep);
    logic [4:0] idx;
    bit         ok;
    int         depth;
    depth = expected_letters.size();
    ok = to_letter(chr, idx);
    case (op)
      ps_pkg::OP_CLEAR: begin
        sq_used  = '0;
        sq_fill  = 0;
        sq_done  = 1'b0;
        held_ok  = 1'b0;
        held_idx = '0;
      end
      ps_pkg::OP_KEY: begin
        if (!sq_done && ok && !sq_used[idx]) begin
          sq_place(idx);
        end
      end
      ps_pkg::OP_TEXT: begin
        sq_complete();
        if (ok) begin
          if (!held_ok) begin
            held_idx = idx;
            held_ok  = 1'b1;
          end else if (!pf_mode && held_idx == idx) begin
            push_pair(held_idx, ps_pkg::LetterX);
          end else begin
            push_pair(held_idx, idx);
            held_ok = 1'b0;
          end
        end
      end
      default: begin
        if (held_ok) begin
          push_pair(held_idx, ps_pkg::LetterX);
          held_ok = 1'b0;
        end
      end
    endcase
    if (!keep) begin
      while (expected_letters.size() > depth) begin
        void'(expected_letters.pop_back());
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  task automatic send_beat(input ps_pkg::ps_op_e op, input logic [7:0] chr,
                           input bit typed = 1'b0);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= chr;
    do @(posedge clk_i); while (!s_tready);
    beats_in++;
    predict_letters(op, chr, !typed);
  endtask

  // lower valid, wait for every pending letter, then let the sequencer finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    pf_mode = m;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(9) == 0) begin
      return 8'($urandom);
    end
    c = 8'd65 + 8'($urandom_range(25));
    if ($urandom_range(1) == 1) begin
      c = c | 8'h20;
    end
    return c;
  endfunction

  // mostly whole messages (clear, key, text, end), the rest loose beats
  task automatic run_phase(input int n_items);
    int         stop_at, n_key, n_text;
    logic [7:0] prev, c;
    stop_at = beats_in + n_items;
    prev = "A";
    while (beats_in < stop_at) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(3) != 0) begin
          send_beat(ps_pkg::OP_CLEAR, 8'($urandom));
        end
        n_key = ($urandom_range(19) == 0) ? 40 : $urandom_range(10);
        repeat (n_key) send_beat(ps_pkg::OP_KEY, rand_char());
        n_text = $urandom_range(1, 14);
        repeat (n_text) begin
          c = ($urandom_range(3) == 0) ? prev : rand_char();
          send_beat(ps_pkg::OP_TEXT, c);
          prev = c;
        end
        if ($urandom_range(7) != 0) begin
          send_beat(ps_pkg::OP_END, 8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(ps_pkg::ps_op_e'($urandom_range(3)), 8'($urandom));
        end
      end
    end
  endtask

  // receiver: random stalls, or a counted hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    letter_beat_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_letters.size() == 0) begin
        report_mismatch($sformatf("letter beat %h with nothing pending", m_tdata));
      end else begin
        want = expected_letters.pop_front();
        if (m_tdata[6:0] !== want.letter) begin
          report_mismatch($sformatf("letter %h, wanted %h", m_tdata[6:0], want.letter));
        end
        if (m_tdata[7] !== 1'b0) begin
          report_mismatch("fill bit of tdata not zero");
        end
        if (m_tlast !== want.last) begin
          report_mismatch($sformatf("tlast %b, wanted %b", m_tlast, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].op, dir_tab[i].chr, dir_tab[i].typed);
      if (dir_tab[i].typed && dir_tab[i].n == 2) begin
        expected_letters.push_back('{dir_tab[i].l0[6:0], 1'b0});
        expected_letters.push_back('{dir_tab[i].l1[6:0], 1'b1});
      end
    end
    settle();
    for (int p = 0; p < NumPhases; p++) begin
      write_mode(ph_mode[p]);
      src_idle_pct   = ph_src[p];
      sink_stall_pct = ph_sink[p];
      // long receiver hold-off while the sender keeps offering
      if (p == 4) begin
        sink_hold = HoldCycles;
      end
      run_phase(PhaseBeats);
      settle();
    end
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
